>>> design/gde_pkg.sv
// Shared constants, types and helpers for the Gaussian-elimination determinant block.
package gde_pkg;

  localparam int MATRIX_ORDER = 4;
  localparam int FRAC_BITS    = 16;
  localparam int CELLS        = MATRIX_ORDER * MATRIX_ORDER;
  localparam int AW           = $clog2(CELLS);
  localparam int IW           = $clog2(MATRIX_ORDER);
  localparam int CW           = $clog2(CELLS + 1);
  localparam int WW           = 48;
  localparam int ELW          = 32;
  localparam int DW           = 64;

  typedef logic signed [WW-1:0] word_t;
  typedef logic [WW-1:0]        mag_t;

  localparam mag_t MAG_CAP = mag_t'(1) << (WW - 1);

  typedef enum logic [4:0] {
    S_LOAD,
    S_FILL,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SW0,
    S_SW1,
    S_SW2,
    S_SW3,
    S_ROW_RD,
    S_ROW_CHK,
    S_DIV_WAIT,
    S_COL_RI,
    S_COL_RK,
    S_COL_CAP,
    S_MUL_WAIT,
    S_ROW_END,
    S_DET_RD,
    S_DET_CHK,
    S_DET_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } unit_st_t;

  function automatic mag_t mag_of(word_t v);
    return v[WW-1] ? ((~mag_t'(v)) + mag_t'(1)) : mag_t'(v);
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
    return AW'(int'(r) * MATRIX_ORDER + int'(c));
  endfunction

endpackage

>>> design/gde_in_if.sv
// Input channel: one matrix element word per handshake.
interface gde_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  logic               last_element;

  modport source(output valid, output element, output last_element, input ready);
  modport sink(input valid, input element, input last_element, output ready);
endinterface

>>> design/gde_out_if.sv
// Output channel: one determinant result word per handshake.
interface gde_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] determinant;
  logic               singular;
  logic               overflow;

  modport source(output valid, output determinant, output singular, output overflow,
                 input ready);
  modport sink(input valid, input determinant, input singular, input overflow,
               output ready);
endinterface

>>> design/gde_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den, capped.
module gde_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gde_pkg::mag_t     num,
  input  gde_pkg::mag_t     den,
  output gde_pkg::mag_t     quo,
  output gde_pkg::unit_st_t st
);
  localparam int STEPS = gde_pkg::WW + gde_pkg::FRAC_BITS;
  localparam int SW    = $clog2(STEPS + 1);

  logic                  busy;
  logic                  done;
  logic [SW-1:0]         cnt;
  gde_pkg::mag_t         nsh;
  gde_pkg::mag_t         den_r;
  gde_pkg::mag_t         rem;
  logic [gde_pkg::WW:0]  q;
  logic                  big;

  logic [gde_pkg::WW:0]  r2;
  logic                  ge;
  gde_pkg::mag_t         rem_next;
  logic [gde_pkg::WW:0]  q_next;
  logic                  big_next;

  always_comb begin
    r2       = {rem, nsh[gde_pkg::WW-1]};
    ge       = r2 >= {1'b0, den_r};
    rem_next = ge ? gde_pkg::WW'(r2 - {1'b0, den_r}) : r2[gde_pkg::WW-1:0];
    q_next   = {q[gde_pkg::WW-1:0], ge};
    big_next = q_next > {1'b0, gde_pkg::MAG_CAP};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        nsh   <= num;
        den_r <= den;
        rem   <= '0;
        q     <= '0;
        big   <= 1'b0;
      end else if (busy) begin
        nsh <= nsh << 1;
        rem <= rem_next;
        if (!big) begin
          q   <= q_next;
          big <= big_next;
        end
        cnt <= cnt + SW'(1);
        if (cnt == SW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = big ? gde_pkg::MAG_CAP : q[gde_pkg::WW-1:0];
  assign st  = '{busy: busy, done: done, sat: big};
endmodule

>>> design/gde_mul.sv
// Digit-serial multiplier: (a * b) >> FRAC_BITS with a cap, one 24x24 product per step.
module gde_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gde_pkg::DW-1:0]    a,
  input  gde_pkg::mag_t             b,
  input  logic [gde_pkg::DW-1:0]    cap,
  output logic [gde_pkg::DW-1:0]    res,
  output gde_pkg::unit_st_t         st
);
  localparam int DG  = 24;
  localparam int ADG = (gde_pkg::DW + DG - 1) / DG;
  localparam int BDG = (gde_pkg::WW + DG - 1) / DG;
  localparam int PW  = DG * (ADG + BDG);
  localparam int XW  = $clog2(ADG);
  localparam int YW  = (BDG > 1) ? $clog2(BDG) : 1;
  localparam int SHW = $clog2(ADG + BDG - 1);

  logic                   busy;
  logic                   done;
  logic                   ph;
  logic [XW-1:0]          xa;
  logic [YW-1:0]          yb;
  logic [SHW-1:0]         sh;
  logic [DG*ADG-1:0]      ar;
  logic [DG*BDG-1:0]      br;
  logic [gde_pkg::DW-1:0] capr;
  logic [2*DG-1:0]        prod;
  logic [PW-1:0]          acc;

  logic [PW-1:0]          full;
  logic                   sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph   <= 1'b0;
        xa   <= '0;
        yb   <= '0;
        acc  <= '0;
        ar   <= (DG*ADG)'(a);
        br   <= (DG*BDG)'(b);
        capr <= cap;
      end else if (busy) begin
        if (!ph) begin
          prod <= (2*DG)'(ar[int'(xa)*DG +: DG] * br[int'(yb)*DG +: DG]);
          sh   <= SHW'(xa) + SHW'(yb);
          ph   <= 1'b1;
        end else begin
          acc <= acc + (PW'(prod) << (DG * int'(sh)));
          ph  <= 1'b0;
          if (yb == YW'(BDG - 1)) begin
            yb <= '0;
            if (xa == XW'(ADG - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              xa <= xa + XW'(1);
            end
          end else begin
            yb <= yb + YW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    full = acc >> gde_pkg::FRAC_BITS;
    sat  = full > PW'(capr);
    res  = sat ? capr : full[gde_pkg::DW-1:0];
  end

  assign st = '{busy: busy, done: done, sat: sat};
endmodule

>>> design/determinant_gauss_elimination.sv
// Determinant by Gaussian elimination: top level with sequencer and matrix memory.
// Elements are taken one word per cycle into a 16-entry memory; the word with
// last_element set starts the computation and the block takes no further input
// until the result is handed to the output register. Missing entries are zeroed
// one per cycle. Elimination then runs on one shared 64-step restoring divider
// (one factor per nonzero subdiagonal entry) and one digit-serial multiplier
// (six 24x24 products per update or diagonal product), with single-port memory
// reads around them. A singular matrix stops early, at the first column with no
// pivot. The result waits in an output register while the next matrix loads.
module determinant_gauss_elimination (
  input  logic        clk,
  input  logic        rst,
  gde_in_if.sink      din,
  gde_out_if.source   dout
);
  localparam logic [gde_pkg::IW-1:0] LAST  = gde_pkg::IW'(gde_pkg::MATRIX_ORDER - 1);
  localparam logic [gde_pkg::DW-1:0] ONE_Q = gde_pkg::DW'(1) << 32;
  localparam logic [gde_pkg::DW-1:0] DET_CAP = gde_pkg::DW'(1) << (gde_pkg::DW - 1);
  localparam logic signed [gde_pkg::WW+1:0] HI = {3'b000, {(gde_pkg::WW-1){1'b1}}};
  localparam logic signed [gde_pkg::WW+1:0] LO = {3'b111, {(gde_pkg::WW-1){1'b0}}};

  gde_pkg::state_t state, state_next;

  gde_pkg::word_t  mat [gde_pkg::CELLS];
  gde_pkg::word_t  rdata;
  logic [gde_pkg::AW-1:0] raddr, waddr;
  logic            we;
  gde_pkg::word_t  wdata;

  logic [gde_pkg::CW-1:0] cnt;
  logic [gde_pkg::IW-1:0] ci, rr, kk, jj;
  gde_pkg::word_t  piv, bij, akj, tmp;
  gde_pkg::mag_t   fmag;
  logic            fneg, fneg_p;
  logic            par, neg, sat_seen, sing;
  logic [gde_pkg::DW-1:0] detmag;

  logic                   ov;
  logic signed [gde_pkg::DW-1:0] det_r;
  logic                   sing_r, ovf_r;

  logic            accept, out_free;

  logic                   div_start;
  gde_pkg::mag_t          div_n, div_d, div_q;
  gde_pkg::unit_st_t      div_st;
  logic                   mul_start;
  logic [gde_pkg::DW-1:0] mul_a, mul_cap, mul_res;
  gde_pkg::mag_t          mul_b;
  gde_pkg::unit_st_t      mul_st;

  logic                   fpos_sat;
  logic                   pneg;
  logic signed [gde_pkg::WW+1:0] akx, px, diff;
  gde_pkg::word_t         upd;
  logic                   negf, dsat;

  gde_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .quo(div_q), .st(div_st)
  );

  gde_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .cap(mul_cap),
    .res(mul_res), .st(mul_st)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mat[waddr] <= wdata;
    end
    rdata <= mat[raddr];
  end

  assign accept   = din.valid && din.ready;
  assign out_free = !ov || dout.ready;

  always_comb begin
    fpos_sat = !fneg_p && (div_q == gde_pkg::MAG_CAP);
    pneg     = fneg ^ bij[gde_pkg::WW-1];
    akx      = {{2{akj[gde_pkg::WW-1]}}, akj};
    px       = pneg ? -$signed({2'b00, mul_res[gde_pkg::WW-1:0]})
                    : $signed({2'b00, mul_res[gde_pkg::WW-1:0]});
    diff     = akx - px;
    if (diff > HI) begin
      upd = HI[gde_pkg::WW-1:0];
    end else if (diff < LO) begin
      upd = LO[gde_pkg::WW-1:0];
    end else begin
      upd = diff[gde_pkg::WW-1:0];
    end
    negf = neg && (detmag != '0);
    dsat = !negf && detmag[gde_pkg::DW-1];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gde_pkg::S_LOAD: begin
        if (accept && din.last_element) state_next = gde_pkg::S_FILL;
      end
      gde_pkg::S_FILL: begin
        if (cnt == gde_pkg::CW'(gde_pkg::CELLS)) state_next = gde_pkg::S_SRCH_RD;
      end
      gde_pkg::S_SRCH_RD: state_next = gde_pkg::S_SRCH_CHK;
      gde_pkg::S_SRCH_CHK: begin
        if (rdata != '0) begin
          if (rr != ci) state_next = gde_pkg::S_SW0;
          else if (ci == LAST) state_next = gde_pkg::S_DET_RD;
          else state_next = gde_pkg::S_ROW_RD;
        end else if (rr == LAST) begin
          state_next = gde_pkg::S_DONE;
        end else begin
          state_next = gde_pkg::S_SRCH_RD;
        end
      end
      gde_pkg::S_SW0: state_next = gde_pkg::S_SW1;
      gde_pkg::S_SW1: state_next = gde_pkg::S_SW2;
      gde_pkg::S_SW2: state_next = gde_pkg::S_SW3;
      gde_pkg::S_SW3: begin
        if (jj != LAST) state_next = gde_pkg::S_SW0;
        else if (ci == LAST) state_next = gde_pkg::S_DET_RD;
        else state_next = gde_pkg::S_ROW_RD;
      end
      gde_pkg::S_ROW_RD: state_next = gde_pkg::S_ROW_CHK;
      gde_pkg::S_ROW_CHK: begin
        state_next = (rdata == '0) ? gde_pkg::S_ROW_END : gde_pkg::S_DIV_WAIT;
      end
      gde_pkg::S_DIV_WAIT: begin
        if (div_st.done) state_next = gde_pkg::S_COL_RI;
      end
      gde_pkg::S_COL_RI:  state_next = gde_pkg::S_COL_RK;
      gde_pkg::S_COL_RK:  state_next = gde_pkg::S_COL_CAP;
      gde_pkg::S_COL_CAP: state_next = gde_pkg::S_MUL_WAIT;
      gde_pkg::S_MUL_WAIT: begin
        if (mul_st.done) begin
          state_next = (jj == LAST) ? gde_pkg::S_ROW_END : gde_pkg::S_COL_RI;
        end
      end
      gde_pkg::S_ROW_END: begin
        state_next = (kk == LAST) ? gde_pkg::S_SRCH_RD : gde_pkg::S_ROW_RD;
      end
      gde_pkg::S_DET_RD:  state_next = gde_pkg::S_DET_CHK;
      gde_pkg::S_DET_CHK: state_next = gde_pkg::S_DET_WAIT;
      gde_pkg::S_DET_WAIT: begin
        if (mul_st.done) begin
          state_next = (rr == LAST) ? gde_pkg::S_DONE : gde_pkg::S_DET_RD;
        end
      end
      gde_pkg::S_DONE: begin
        if (out_free) state_next = gde_pkg::S_LOAD;
      end
      default: state_next = gde_pkg::S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    din.ready = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    div_start = 1'b0;
    div_n     = gde_pkg::mag_of(rdata);
    div_d     = gde_pkg::mag_of(piv);
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_cap   = '0;
    unique case (state)
      gde_pkg::S_LOAD: begin
        din.ready = 1'b1;
        we    = accept && (cnt < gde_pkg::CW'(gde_pkg::CELLS));
        waddr = cnt[gde_pkg::AW-1:0];
        wdata = {{(gde_pkg::WW-gde_pkg::ELW){din.element[gde_pkg::ELW-1]}}, din.element};
      end
      gde_pkg::S_FILL: begin
        we    = cnt < gde_pkg::CW'(gde_pkg::CELLS);
        waddr = cnt[gde_pkg::AW-1:0];
      end
      gde_pkg::S_SRCH_RD: raddr = gde_pkg::addr_of(rr, ci);
      gde_pkg::S_SW0:     raddr = gde_pkg::addr_of(ci, jj);
      gde_pkg::S_SW1:     raddr = gde_pkg::addr_of(rr, jj);
      gde_pkg::S_SW2: begin
        we    = 1'b1;
        waddr = gde_pkg::addr_of(ci, jj);
        wdata = rdata;
      end
      gde_pkg::S_SW3: begin
        we    = 1'b1;
        waddr = gde_pkg::addr_of(rr, jj);
        wdata = tmp;
      end
      gde_pkg::S_ROW_RD:  raddr = gde_pkg::addr_of(kk, ci);
      gde_pkg::S_ROW_CHK: div_start = rdata != '0;
      gde_pkg::S_COL_RI:  raddr = gde_pkg::addr_of(ci, jj);
      gde_pkg::S_COL_RK:  raddr = gde_pkg::addr_of(kk, jj);
      gde_pkg::S_COL_CAP: begin
        mul_start = 1'b1;
        mul_a     = gde_pkg::DW'(fmag);
        mul_b     = gde_pkg::mag_of(bij);
        mul_cap   = gde_pkg::DW'(gde_pkg::MAG_CAP);
      end
      gde_pkg::S_MUL_WAIT: begin
        we    = mul_st.done;
        waddr = gde_pkg::addr_of(kk, jj);
        wdata = upd;
      end
      gde_pkg::S_DET_RD: raddr = gde_pkg::addr_of(rr, rr);
      gde_pkg::S_DET_CHK: begin
        mul_start = 1'b1;
        mul_a     = detmag;
        mul_b     = gde_pkg::mag_of(rdata);
        mul_cap   = DET_CAP;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gde_pkg::S_LOAD;
      cnt   <= '0;
      par   <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gde_pkg::S_DONE && out_free) ov <= 1'b1;
      else if (dout.ready) ov <= 1'b0;
      unique case (state)
        gde_pkg::S_LOAD: begin
          if (accept) begin
            if (cnt < gde_pkg::CW'(gde_pkg::CELLS)) cnt <= cnt + gde_pkg::CW'(1);
            if (din.last_element) begin
              ci       <= '0;
              rr       <= '0;
              par      <= 1'b0;
              sat_seen <= 1'b0;
              sing     <= 1'b0;
            end
          end
        end
        gde_pkg::S_FILL: begin
          if (cnt == gde_pkg::CW'(gde_pkg::CELLS)) cnt <= '0;
          else cnt <= cnt + gde_pkg::CW'(1);
        end
        gde_pkg::S_SRCH_CHK: begin
          if (rdata != '0) begin
            piv    <= rdata;
            jj     <= ci;
            kk     <= ci + gde_pkg::IW'(1);
            detmag <= ONE_Q;
            if (rr != ci) begin
              par <= ~par;
            end else begin
              rr  <= '0;
              neg <= par;
            end
          end else if (rr == LAST) begin
            sing <= 1'b1;
          end else begin
            rr <= rr + gde_pkg::IW'(1);
          end
        end
        gde_pkg::S_SW1: tmp <= rdata;
        gde_pkg::S_SW3: begin
          if (jj != LAST) begin
            jj <= jj + gde_pkg::IW'(1);
          end else begin
            rr  <= '0;
            neg <= par;
          end
        end
        gde_pkg::S_ROW_CHK: fneg_p <= rdata[gde_pkg::WW-1] ^ piv[gde_pkg::WW-1];
        gde_pkg::S_DIV_WAIT: begin
          if (div_st.done) begin
            fmag     <= fpos_sat ? (gde_pkg::MAG_CAP - gde_pkg::mag_t'(1)) : div_q;
            fneg     <= fneg_p && (div_q != '0);
            sat_seen <= sat_seen | div_st.sat | fpos_sat;
            jj       <= ci + gde_pkg::IW'(1);
          end
        end
        gde_pkg::S_COL_RK:  bij <= rdata;
        gde_pkg::S_COL_CAP: akj <= rdata;
        gde_pkg::S_MUL_WAIT: begin
          if (mul_st.done) begin
            sat_seen <= sat_seen | mul_st.sat | (diff > HI) | (diff < LO);
            if (jj != LAST) jj <= jj + gde_pkg::IW'(1);
          end
        end
        gde_pkg::S_ROW_END: begin
          if (kk == LAST) begin
            ci <= ci + gde_pkg::IW'(1);
            rr <= ci + gde_pkg::IW'(1);
          end else begin
            kk <= kk + gde_pkg::IW'(1);
          end
        end
        gde_pkg::S_DET_CHK: neg <= neg ^ rdata[gde_pkg::WW-1];
        gde_pkg::S_DET_WAIT: begin
          if (mul_st.done) begin
            detmag   <= mul_res;
            sat_seen <= sat_seen | mul_st.sat;
            rr       <= rr + gde_pkg::IW'(1);
          end
        end
        gde_pkg::S_DONE: begin
          if (out_free) begin
            sing_r <= sing;
            if (sing) begin
              det_r <= '0;
              ovf_r <= sat_seen;
            end else begin
              det_r <= dsat ? $signed(DET_CAP - gde_pkg::DW'(1))
                            : (negf ? -$signed(detmag) : $signed(detmag));
              ovf_r <= sat_seen | dsat;
            end
            par <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign dout.valid       = ov;
  assign dout.determinant = det_r;
  assign dout.singular    = sing_r;
  assign dout.overflow    = ovf_r;

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.singular) |-> (dout.determinant == '0))
    else $error("singular result with nonzero determinant");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= gde_pkg::CW'(gde_pkg::CELLS))
    else $error("load count past matrix size");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_st.busy && mul_st.busy))
    else $error("divider and multiplier busy together");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == gde_pkg::S_DONE && out_free) |=> dout.valid)
    else $error("result not presented after completion");
endmodule
